[rtl/psfe_pkg.sv]
// Shared types and constants for the particulate sensor frame emitter.
`default_nettype none
package psfe_pkg;

  // Event codes on the operation field
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SLEEP = 2'd1;
  localparam logic [1:0] OP_RESET = 2'd2;

  // Configuration register indexes
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_MAX      = 1'b1;

  // Configuration reset values
  localparam logic [23:0] INTERVAL_RESET = 24'd1000000;
  localparam logic [15:0] MAX_RESET      = 16'd500;

  // Fixed frame header bytes
  localparam logic [7:0] HDR_0 = 8'h42;
  localparam logic [7:0] HDR_1 = 8'h4D;
  localparam logic [7:0] HDR_2 = 8'h00;
  localparam logic [7:0] HDR_3 = 8'h1C;
  localparam logic [15:0] HDR_SUM = 16'h00AB;

  // Frame geometry
  localparam int FRAME_LEN = 32;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FRAME_LEN - 1);

  // Request queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One frame request: the three clamped readings
  typedef struct packed {
    logic [15:0] pm1;
    logic [15:0] pm25;
    logic [15:0] pm10;
  } frame_req_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

[rtl/psfe_front.sv]
// Front end: takes events, tracks sleep and interval state, queues frame requests.
`default_nettype none
module psfe_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [23:0]           cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            operation,
  input  wire logic                  sleep_pin,
  input  wire logic [15:0]           pm1_reading,
  input  wire logic [15:0]           pm25_reading,
  input  wire logic [15:0]           pm10_reading,
  input  wire psfe_pkg::q_status_t   q_stat,
  output logic                       q_push,
  output psfe_pkg::frame_req_t       q_entry
);

  logic [23:0] interval_ticks;
  logic [15:0] max_reading;
  logic        asleep;
  logic        asleep_next;
  logic [23:0] tick_count;
  logic [23:0] tick_count_next;
  logic [24:0] tick_inc;
  logic        accept;
  logic        emit;

  // Hold requests back while the queue is full
  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign tick_inc = {1'b0, tick_count} + 25'd1;

  // Clamp readings into the queued request
  assign q_entry.pm1  = (pm1_reading  > max_reading) ? max_reading : pm1_reading;
  assign q_entry.pm25 = (pm25_reading > max_reading) ? max_reading : pm25_reading;
  assign q_entry.pm10 = (pm10_reading > max_reading) ? max_reading : pm10_reading;
  assign q_push = accept && emit;

  // Classify the event
  always_comb begin
    asleep_next     = asleep;
    tick_count_next = tick_count;
    emit            = 1'b0;
    case (operation)
      psfe_pkg::OP_TICK: begin
        if (!asleep) begin
          if (tick_inc >= {1'b0, interval_ticks}) begin
            tick_count_next = '0;
            emit            = 1'b1;
          end else begin
            tick_count_next = tick_inc[23:0];
          end
        end
      end
      psfe_pkg::OP_SLEEP: begin
        if (!sleep_pin && !asleep) begin
          asleep_next = 1'b1;
        end else if (sleep_pin && asleep) begin
          asleep_next     = 1'b0;
          tick_count_next = '0;
          emit            = 1'b1;
        end
      end
      psfe_pkg::OP_RESET: begin
        if (asleep) begin
          asleep_next     = 1'b0;
          tick_count_next = '0;
        end
        emit = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Update configuration and event state
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ticks <= psfe_pkg::INTERVAL_RESET;
      max_reading    <= psfe_pkg::MAX_RESET;
      asleep         <= 1'b0;
      tick_count     <= '0;
    end else begin
      if (cfg_we && cfg_index == psfe_pkg::REG_INTERVAL) begin
        interval_ticks <= cfg_data;
      end
      if (cfg_we && cfg_index == psfe_pkg::REG_MAX) begin
        max_reading <= cfg_data[15:0];
      end
      if (accept) begin
        asleep     <= asleep_next;
        tick_count <= tick_count_next;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/psfe_queue.sv]
// Short request queue between the front end and the frame sender.
`default_nettype none
module psfe_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire psfe_pkg::frame_req_t  wr_entry,
  input  wire logic                  pop,
  output psfe_pkg::frame_req_t       rd_entry,
  output psfe_pkg::q_status_t        stat
);

  psfe_pkg::frame_req_t              mem [psfe_pkg::QDEPTH];
  logic [psfe_pkg::QPTR_W-1:0]       wr_ptr;
  logic [psfe_pkg::QPTR_W-1:0]       rd_ptr;
  logic [psfe_pkg::QCNT_W-1:0]       count;

  assign stat.full  = (count == psfe_pkg::QCNT_W'(psfe_pkg::QDEPTH));
  assign stat.empty = (count == '0);
  assign rd_entry   = mem[rd_ptr];

  // Store requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/psfe_back.sv]
// Back end: walks one queued request through the 32 frame bytes.
`default_nettype none
module psfe_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire psfe_pkg::q_status_t   q_stat,
  input  wire psfe_pkg::frame_req_t  q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 frame_byte,
  output logic                       last_byte
);

  logic                          busy;
  logic [psfe_pkg::IDX_W-1:0]    idx;
  psfe_pkg::frame_req_t          cur;
  logic [15:0]                   sum;
  logic                          advance;
  logic                          at_last;

  assign out_valid = busy;
  assign at_last   = (idx == psfe_pkg::IDX_LAST);
  assign last_byte = at_last;
  assign advance   = busy && !out_stall;
  // Load the next request when idle or when the last byte leaves
  assign q_pop     = !q_stat.empty && (!busy || (advance && at_last));

  // Checksum of bytes 0 to 29
  assign sum = psfe_pkg::HDR_SUM
             + {8'd0, cur.pm1[15:8]}  + {8'd0, cur.pm1[7:0]}
             + {8'd0, cur.pm25[15:8]} + {8'd0, cur.pm25[7:0]}
             + {8'd0, cur.pm10[15:8]} + {8'd0, cur.pm10[7:0]};

  // Select the byte at the current position
  always_comb begin
    case (idx)
      5'd0:    frame_byte = psfe_pkg::HDR_0;
      5'd1:    frame_byte = psfe_pkg::HDR_1;
      5'd2:    frame_byte = psfe_pkg::HDR_2;
      5'd3:    frame_byte = psfe_pkg::HDR_3;
      5'd4:    frame_byte = cur.pm1[15:8];
      5'd5:    frame_byte = cur.pm1[7:0];
      5'd6:    frame_byte = cur.pm25[15:8];
      5'd7:    frame_byte = cur.pm25[7:0];
      5'd8:    frame_byte = cur.pm10[15:8];
      5'd9:    frame_byte = cur.pm10[7:0];
      5'd30:   frame_byte = sum[15:8];
      5'd31:   frame_byte = sum[7:0];
      default: frame_byte = 8'd0;
    endcase
  end

  // Hold the request payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  // Advance through the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (advance) begin
      if (at_last) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/particulate_sensor_frame_emitter_core.sv]
// Top level of the particulate sensor frame emitter.
//
// Input channel: one event per request (tick, sleep pin change, reset pin
// falling edge) with the three current readings, taken when in_valid is high
// and in_stall is low. Output channel: one frame byte per request, taken when
// out_valid is high and out_stall is low; last_byte marks the low checksum
// byte, the 32nd byte of a frame.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 interval_ticks, 1 max_reading); write only while the block is idle.
// The first byte of a frame is offered once its request has passed through
// the queue and been loaded into the byte walker. A frame holds the output
// until its 32 bytes have left; the byte walker loads the next queued request
// in the same cycle the last byte leaves, so frames stream back to back while
// requests wait. Requests that cause no frame are not queued. A two-entry
// queue sits between the event front end and the byte walker, so in_stall
// rises only when two frame requests wait.
// Reset clears the sleep flag, the tick counter, the queue and the walker,
// and loads the configuration reset values. When the receiver stalls, the
// current byte holds and the queue fills, then in_stall rises.
`default_nettype none
module particulate_sensor_frame_emitter_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [23:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  operation,
  input  wire logic        sleep_pin,
  input  wire logic [15:0] pm1_reading,
  input  wire logic [15:0] pm25_reading,
  input  wire logic [15:0] pm10_reading,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       frame_byte,
  output logic             last_byte
);

  psfe_pkg::q_status_t  q_stat;
  psfe_pkg::frame_req_t wr_entry;
  psfe_pkg::frame_req_t rd_entry;
  logic                 q_push;
  logic                 q_pop;

  psfe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .sleep_pin    (sleep_pin),
    .pm1_reading  (pm1_reading),
    .pm25_reading (pm25_reading),
    .pm10_reading (pm10_reading),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_entry      (wr_entry)
  );

  psfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .stat     (q_stat)
  );

  psfe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_stat     (q_stat),
    .q_entry    (rd_entry),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_byte (frame_byte),
    .last_byte  (last_byte)
  );

  // No request is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("frame request pushed into full queue");

  // No request is popped from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("frame request popped from empty queue");

  // A frame ends only after its last byte was taken
  a_frame_whole: assert property (@(posedge clk) disable iff (rst)
    $fell(out_valid) |-> ($past(last_byte) && !$past(out_stall)))
    else $error("frame output ended before the checksum byte");

endmodule
`default_nettype wire
